@@ rtl/fra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_pkg
// Shared widths, operation codes, datapath commands and controller states for
// the fraction arithmetic and reduction core.
// ----------------------------------------------------------------------------
package fra_pkg;

    localparam int OPERAND_W = 16;
    localparam int PROD_W    = 2 * OPERAND_W;
    localparam int NUM_W     = 2 * OPERAND_W + 1;
    localparam int MAG_W     = 2 * OPERAND_W;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(MAG_W + 1);

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MAG,
        OP_REM_START,
        OP_REM_TAKE,
        OP_QN_START,
        OP_QN_TAKE,
        OP_QD_START,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic y_zero;
        logic div_done;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MAG,
        S_GCD_CHK,
        S_REM_WAIT,
        S_QN_WAIT,
        S_QD_START,
        S_QD_WAIT
    } ctrl_state_t;

endpackage

@@ rtl/fra_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_div
// Unsigned restoring divider, one quotient bit per cycle, giving quotient and
// remainder. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module fra_div
    import fra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [MAG_W-1:0] divisor,
    output logic [MAG_W-1:0] quo,
    output logic [MAG_W-1:0] rem,
    output logic             done
);

    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [MAG_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [MAG_W:0]   shifted;
    logic [MAG_W+1:0] diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = ~diff[MAG_W+1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit and subtract where it fits
            quo_next = {quo_reg[MAG_W-2:0], fits};
            rem_next = fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

@@ rtl/fra_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_dp
// Datapath: operand registers, one shared multiplier, numerator accumulator,
// Euclid registers around the divider, and the result registers.
// ----------------------------------------------------------------------------
module fra_dp
    import fra_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  logic [1:0]                  kind,
    input  logic signed [OPERAND_W-1:0] a_num,
    input  logic signed [OPERAND_W-1:0] a_den,
    input  logic signed [OPERAND_W-1:0] b_num,
    input  logic signed [OPERAND_W-1:0] b_den,
    output logic                        done,
    output logic signed [RES_NUM_W-1:0] res_num,
    output logic signed [RES_DEN_W-1:0] res_den
);

    localparam logic signed [OPERAND_W-1:0] ONE_OP = OPERAND_W'(1);

    kind_t                       kind_reg, kind_next;
    logic signed [OPERAND_W-1:0] an_reg, an_next;
    logic signed [OPERAND_W-1:0] ad_reg, ad_next;
    logic signed [OPERAND_W-1:0] bn_reg, bn_next;
    logic signed [OPERAND_W-1:0] bd_reg, bd_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [NUM_W-1:0]     n_reg, n_next;
    logic                        n_neg_reg, n_neg_next;
    logic                        d_neg_reg, d_neg_next;
    logic [MAG_W-1:0]            magn_reg, magn_next;
    logic [MAG_W-1:0]            magd_reg, magd_next;
    logic [MAG_W-1:0]            x_reg, x_next;
    logic [MAG_W-1:0]            y_reg, y_next;
    logic [MAG_W-1:0]            qn_reg, qn_next;
    logic [RES_NUM_W-1:0]        res_num_reg, res_num_next;
    logic [RES_DEN_W-1:0]        res_den_reg, res_den_next;
    logic                        done_reg, done_next;

    logic signed [OPERAND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]    prod_c;
    logic signed [NUM_W-1:0]     n_abs;
    logic signed [PROD_W-1:0]    d_abs;
    logic                        div_start;
    logic [MAG_W-1:0]            div_dividend, div_divisor;
    logic [MAG_W-1:0]            div_quo, div_rem;
    logic                        div_done;
    logic [NUM_W-1:0]            num_ext, num_val;
    logic [MAG_W:0]              den_ext, den_val;

    // shared multiplier operand selection
    always_comb
    begin
        case (cmd.op)
            OP_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (kind_reg == KIND_MUL) ? bn_reg : bd_reg;
            end
            OP_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (kind_reg == KIND_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign n_abs  = n_reg[NUM_W-1] ? -n_reg : n_reg;
    assign d_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    assign div_start = (cmd.op == OP_REM_START) || (cmd.op == OP_QN_START)
                    || (cmd.op == OP_QD_START);

    always_comb
    begin
        case (cmd.op)
            OP_REM_START:
            begin
                div_dividend = x_reg;
                div_divisor  = y_reg;
            end
            OP_QN_START:
            begin
                div_dividend = magn_reg;
                div_divisor  = x_reg;
            end
            default:
            begin
                div_dividend = magd_reg;
                div_divisor  = x_reg;
            end
        endcase
    end

    fra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    // restore the signs on the reduced magnitudes
    assign num_ext = {1'b0, qn_reg};
    assign num_val = n_neg_reg ? (~num_ext + NUM_W'(1)) : num_ext;
    assign den_ext = {1'b0, div_quo};
    assign den_val = d_neg_reg ? (~den_ext + (MAG_W + 1)'(1)) : den_ext;

    always_comb
    begin
        kind_next    = kind_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        prod_next    = prod_reg;
        n_next       = n_reg;
        n_neg_next   = n_neg_reg;
        d_neg_next   = d_neg_reg;
        magn_next    = magn_reg;
        magd_next    = magd_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        qn_next      = qn_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        done_next    = 1'b0;
        case (cmd.op)
            OP_LOAD:
            begin
                kind_next = kind_t'(kind);
                an_next   = a_num;
                ad_next   = (a_den == '0) ? ONE_OP : a_den;
                bn_next   = b_num;
                bd_next   = (b_den == '0) ? ONE_OP : b_den;
            end
            OP_MUL0:
            begin
                prod_next = prod_c;
            end
            OP_MUL1:
            begin
                n_next    = NUM_W'(prod_reg);
                prod_next = prod_c;
            end
            OP_MUL2:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    n_next = n_reg + NUM_W'(prod_reg);
                end
                else if (kind_reg == KIND_SUB)
                begin
                    n_next = n_reg - NUM_W'(prod_reg);
                end
                prod_next = prod_c;
            end
            OP_MAG:
            begin
                n_neg_next = n_reg[NUM_W-1];
                magn_next  = n_abs[MAG_W-1:0];
                x_next     = n_abs[MAG_W-1:0];
                // a zero denominator only arises from dividing by zero: take one
                if (prod_reg == '0)
                begin
                    d_neg_next = 1'b0;
                    magd_next  = MAG_W'(1);
                    y_next     = MAG_W'(1);
                end
                else
                begin
                    d_neg_next = prod_reg[PROD_W-1];
                    magd_next  = d_abs[MAG_W-1:0];
                    y_next     = d_abs[MAG_W-1:0];
                end
            end
            OP_REM_TAKE:
            begin
                x_next = y_reg;
                y_next = div_rem;
            end
            OP_QN_TAKE:
            begin
                qn_next = div_quo;
            end
            OP_EMIT:
            begin
                res_num_next = RES_NUM_W'($signed(num_val));
                res_den_next = RES_DEN_W'($signed(den_val));
                done_next    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        prod_reg    <= prod_next;
        n_reg       <= n_next;
        n_neg_reg   <= n_neg_next;
        d_neg_reg   <= d_neg_next;
        magn_reg    <= magn_next;
        magd_reg    <= magd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        qn_reg      <= qn_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
    end

    assign stat.y_zero   = (y_reg == '0);
    assign stat.div_done = div_done;

    assign done    = done_reg;
    assign res_num = $signed(res_num_reg);
    assign res_den = $signed(res_den_reg);

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_den_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_den_reg != '0))
        else $error("reduced denominator is zero");

endmodule

@@ rtl/fra_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_ctrl
// Controller: sequences the multiplies, the Euclid remainder loop and the two
// final divisions, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module fra_ctrl
    import fra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.op     = OP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = S_GCD_CHK;
            end
            S_GCD_CHK:
            begin
                // remainder zero: x holds the GCD, go reduce
                if (stat.y_zero)
                begin
                    cmd.op     = OP_QN_START;
                    state_next = S_QN_WAIT;
                end
                else
                begin
                    cmd.op     = OP_REM_START;
                    state_next = S_REM_WAIT;
                end
            end
            S_REM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_REM_TAKE;
                    state_next = S_GCD_CHK;
                end
            end
            S_QN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_QN_TAKE;
                    state_next = S_QD_START;
                end
            end
            S_QD_START:
            begin
                cmd.op     = OP_QD_START;
                state_next = S_QD_WAIT;
            end
            S_QD_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_div_done_waiting : assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_REM_WAIT || state_reg == S_QN_WAIT
                           || state_reg == S_QD_WAIT))
        else $error("divider finished outside a wait state");

    a_emit_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after the result");

    a_start_taken : assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == S_IDLE) |=> (state_reg == S_MUL0))
        else $error("accepted command did not begin the multiply sequence");

endmodule

@@ rtl/fraction_arithmetic_reduce_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce_core
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result by the GCD of its parts, each part keeping its own sign.
//
// Usage:
//   A command transfer happens on a rising edge with start high and busy low;
//   kind, a_num, a_den, b_num and b_den are sampled on that edge. A zero input
//   denominator counts as one, and a zero raw denominator becomes one.
//   The result appears on res_num / res_den, marked by done high for a single
//   cycle; the receiver must take it then, as it cannot stall the core.
//   A command runs through loading and multiplying, then one bit-serial
//   division per Euclid remainder step (at least one step), then two
//   further divisions; the shared one-bit-per-cycle divider sets its run
//   time. One command is in flight at a time; busy drops as done rises, so
//   the next command can be given in the cycle that done is shown.
//   Reset clears the controller to idle and drops done; no clearing pass.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reduce_core
    import fra_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic signed [OPERAND_W-1:0] a_num,
    input  logic signed [OPERAND_W-1:0] a_den,
    input  logic signed [OPERAND_W-1:0] b_num,
    input  logic signed [OPERAND_W-1:0] b_den,
    output logic                        done,
    output logic signed [RES_NUM_W-1:0] res_num,
    output logic signed [RES_DEN_W-1:0] res_den
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    fra_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .kind    (kind),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .done    (done),
        .res_num (res_num),
        .res_den (res_den)
    );

endmodule
